// ===== src/isst_pkg.sv =====
package isst_pkg;

   localparam logic [2:0] CMD_INSERT_AT     = 3'd0;
   localparam logic [2:0] CMD_INSERT_SORTED = 3'd1;
   localparam logic [2:0] CMD_ERASE_AT      = 3'd2;
   localparam logic [2:0] CMD_REMOVE_ALL    = 3'd3;
   localparam logic [2:0] CMD_GET           = 3'd4;
   localparam logic [2:0] CMD_SET           = 3'd5;
   localparam logic [2:0] CMD_FIND          = 3'd6;

   localparam logic [1:0] STS_OK        = 2'd0;
   localparam logic [1:0] STS_BAD_POS   = 2'd1;
   localparam logic [1:0] STS_FULL      = 2'd2;
   localparam logic [1:0] STS_NOT_FOUND = 2'd3;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_EXEC
   } state_type;

   // per-cycle command broadcast to every cell
   typedef struct packed {
      logic shift_up;
      logic shift_down;
      logic write;
   } cell_ctrl_type;

endpackage

// ===== src/isst_cell.sv =====
module isst_cell import isst_pkg::*; #(
   parameter int ITEM_WIDTH = 32,
   parameter int AW         = 6,
   parameter int IDX        = 0
) (
   input  logic                  clock,
   input  cell_ctrl_type         ctrl,
   input  logic [AW-1:0]         at,
   input  logic [ITEM_WIDTH-1:0] wdata,
   input  logic [ITEM_WIDTH-1:0] key,
   input  logic [ITEM_WIDTH-1:0] prev_val,
   input  logic [ITEM_WIDTH-1:0] next_val,
   output logic [ITEM_WIDTH-1:0] val,
   output logic                  eq,
   output logic                  lt
);

   localparam logic [AW-1:0] MY_IDX = AW'(IDX);

   logic [ITEM_WIDTH-1:0] val_ff;
   logic [ITEM_WIDTH-1:0] val_in;

   always_comb begin
      val_in = val_ff;
      if (ctrl.write && at == MY_IDX) begin
         val_in = wdata;
      end else if (ctrl.shift_up && MY_IDX > at) begin
         val_in = prev_val;
      end else if (ctrl.shift_down && MY_IDX >= at) begin
         val_in = next_val;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

   assign val = val_ff;
   assign eq  = (val_ff == key);
   assign lt  = (val_ff < key);

endmodule

// ===== src/indexed_sequence_store_top.sv =====
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_ready  req_cmd, req_position, req_item_value
// rsp       out        rsp_valid/rsp_ready  rsp_status, rsp_result_index,
//                                           rsp_read_value, rsp_occupancy
// One transaction at a time. After the accept, get, set, insert_at and erase_at
// complete directly; insert_sorted, find and remove_all walk the cells one index
// a cycle (remove_all rechecks an index after a removal); the cells shift at once.
// Reset empties the store at once; cell contents are not cleared.
// A held response stalls the final step; the next request waits for it to finish.
module indexed_sequence_store_top import isst_pkg::*; #(
   parameter int CAPACITY   = 64,
   parameter int ITEM_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_cmd,
   input  logic [6:0]  req_position,
   input  logic [31:0] req_item_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [6:0]  rsp_result_index,
   output logic [31:0] rsp_read_value,
   output logic [6:0]  rsp_occupancy
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int WW = (CW > 7) ? CW : 7;
   localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

   state_type state_ff, state_in;
   logic [2:0]            cmd_ff;
   logic [WW-1:0]         pos_ff;
   logic [ITEM_WIDTH-1:0] key_ff;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [CW-1:0]         k_ff, k_in;
   logic [CW-1:0]         rem_ff, rem_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            status_ff, status_in;
   logic [6:0]            ridx_ff, ridx_in;
   logic [31:0]           rval_ff, rval_in;
   logic [6:0]            occ_ff;

   cell_ctrl_type         ctrl;
   logic [AW-1:0]         at;
   logic [ITEM_WIDTH-1:0] cell_val [CAPACITY];
   logic [CAPACITY-1:0]   eq_vec, lt_vec;

   logic                  slot_free, done;
   logic [WW-1:0]         cnt_w;
   logic                  scan_live;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign cnt_w     = WW'(cnt_ff);
   assign scan_live = (k_ff < cnt_ff);

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         logic [ITEM_WIDTH-1:0] prev_v, next_v;
         if (g == 0) begin : g_first
            assign prev_v = '0;
         end else begin : g_mid
            assign prev_v = cell_val[g-1];
         end
         if (g == CAPACITY - 1) begin : g_last
            assign next_v = '0;
         end else begin : g_body
            assign next_v = cell_val[g+1];
         end
         isst_cell #(
            .ITEM_WIDTH (ITEM_WIDTH),
            .AW         (AW),
            .IDX        (g)
         ) u_cell (
            .clock    (clock),
            .ctrl     (ctrl),
            .at       (at),
            .wdata    (key_ff),
            .key      (key_ff),
            .prev_val (prev_v),
            .next_val (next_v),
            .val      (cell_val[g]),
            .eq       (eq_vec[g]),
            .lt       (lt_vec[g])
         );
      end
   endgenerate

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_EXEC;
         ST_EXEC: if (done && slot_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);

   // command datapath
   always_comb begin
      ctrl      = '0;
      at        = pos_ff[AW-1:0];
      cnt_in    = cnt_ff;
      k_in      = k_ff;
      rem_in    = rem_ff;
      done      = 1'b0;
      status_in = STS_OK;
      ridx_in   = '0;
      rval_in   = '0;
      if (state_ff == ST_EXEC) begin
         unique case (cmd_ff)
            CMD_INSERT_AT: begin
               done = 1'b1;
               if (pos_ff > cnt_w) begin
                  status_in = STS_BAD_POS;
               end else if (cnt_ff == CAP_CNT) begin
                  status_in = STS_FULL;
               end else begin
                  ridx_in = 7'(pos_ff);
                  if (slot_free) begin
                     ctrl.shift_up = 1'b1;
                     ctrl.write    = 1'b1;
                     cnt_in        = cnt_ff + 1'b1;
                  end
               end
            end
            CMD_INSERT_SORTED: begin
               at = k_ff[AW-1:0];
               if (cnt_ff == CAP_CNT) begin
                  done      = 1'b1;
                  status_in = STS_FULL;
               end else if (scan_live && lt_vec[k_ff[AW-1:0]]) begin
                  k_in = k_ff + 1'b1;
               end else begin
                  done    = 1'b1;
                  ridx_in = 7'(k_ff);
                  if (slot_free) begin
                     ctrl.shift_up = 1'b1;
                     ctrl.write    = 1'b1;
                     cnt_in        = cnt_ff + 1'b1;
                  end
               end
            end
            CMD_ERASE_AT: begin
               done = 1'b1;
               if (pos_ff >= cnt_w) begin
                  status_in = STS_BAD_POS;
               end else begin
                  ridx_in = 7'(pos_ff);
                  if (slot_free) begin
                     ctrl.shift_down = 1'b1;
                     cnt_in          = cnt_ff - 1'b1;
                  end
               end
            end
            CMD_REMOVE_ALL: begin
               at = k_ff[AW-1:0];
               if (scan_live) begin
                  if (eq_vec[k_ff[AW-1:0]]) begin
                     // close the gap and recheck the same index
                     ctrl.shift_down = 1'b1;
                     cnt_in          = cnt_ff - 1'b1;
                     rem_in          = rem_ff + 1'b1;
                  end else begin
                     k_in = k_ff + 1'b1;
                  end
               end else begin
                  done    = 1'b1;
                  ridx_in = 7'(rem_ff);
               end
            end
            CMD_GET: begin
               done = 1'b1;
               if (pos_ff >= cnt_w) status_in = STS_BAD_POS;
               else rval_in = 32'(cell_val[pos_ff[AW-1:0]]);
            end
            CMD_SET: begin
               done = 1'b1;
               if (pos_ff >= cnt_w) begin
                  status_in = STS_BAD_POS;
               end else begin
                  ridx_in    = 7'(pos_ff);
                  ctrl.write = slot_free;
               end
            end
            CMD_FIND: begin
               if (scan_live) begin
                  if (eq_vec[k_ff[AW-1:0]]) begin
                     done    = 1'b1;
                     ridx_in = 7'(k_ff);
                  end else begin
                     k_in = k_ff + 1'b1;
                  end
               end else begin
                  done      = 1'b1;
                  status_in = STS_NOT_FOUND;
               end
            end
            default: begin
               done      = 1'b1;
               status_in = STS_BAD_POS;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) rsp_valid_in = 1'b0;
      if (state_ff == ST_EXEC && done && slot_free) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         cmd_ff <= req_cmd;
         pos_ff <= WW'(req_position);
         key_ff <= ITEM_WIDTH'(req_item_value);
         k_ff   <= '0;
         rem_ff <= '0;
      end else begin
         k_ff   <= k_in;
         rem_ff <= rem_in;
      end
      if (state_ff == ST_EXEC && done && slot_free) begin
         status_ff <= status_in;
         ridx_ff   <= ridx_in;
         rval_ff   <= rval_in;
         occ_ff    <= 7'(cnt_in);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_result_index = ridx_ff;
   assign rsp_read_value   = rval_ff;
   assign rsp_occupancy    = occ_ff;

endmodule

// ===== src/isst_checker.sv =====
module isst_checker import isst_pkg::*; #(
   parameter int CAPACITY = 64
) (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [6:0]  rsp_result_index,
   input logic [31:0] rsp_read_value,
   input logic [6:0]  rsp_occupancy
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_occupancy))
      else $error("response dropped while stalled");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STS_OK |-> rsp_result_index == 7'd0 && rsp_read_value == 32'd0)
      else $error("error response carries data");

   a_occ_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (CAPACITY > 127) || (rsp_occupancy <= 7'(CAPACITY)))
      else $error("occupancy above capacity");

   a_full_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STS_FULL |-> (CAPACITY > 127) || (rsp_occupancy == 7'(CAPACITY)))
      else $error("full status with free space");

endmodule

bind indexed_sequence_store_top isst_checker #(.CAPACITY(CAPACITY)) u_isst_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_status       (rsp_status),
   .rsp_result_index (rsp_result_index),
   .rsp_read_value   (rsp_read_value),
   .rsp_occupancy    (rsp_occupancy)
);
